// File: src/assert_macros.svh
// Assertion macros shared by the string group converter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a condition.
`define ASSERT_NEXT(lbl, clk, rst, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: src/utfsg_pkg.sv
// Types, codes and helpers shared by the string group converter
`default_nettype none

package utfsg_pkg;

  localparam int unsigned RunMax = 4;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERRUN   = 2'd1,
    ERR_SURROGATE = 2'd2
  } err_t;

  typedef enum logic [6:0] {
    PH_LEN_LO  = 7'b0000001,
    PH_LEN_HI  = 7'b0000010,
    PH_PFX1    = 7'b0000100,
    PH_PFX2    = 7'b0001000,
    PH_UNIT_LO = 7'b0010000,
    PH_UNIT_HI = 7'b0100000,
    PH_DRAIN   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       str_end;
    logic       done;
    err_t       err;
  } result_t;

  typedef struct packed {
    logic [2:0]              count;
    result_t [RunMax-1:0]    res;
  } run_t;

  function automatic result_t mk_res(logic [7:0] data, logic valid, logic str_end,
                                     logic done, err_t err);
    result_t r;
    r.data    = data;
    r.valid   = valid;
    r.str_end = str_end;
    r.done    = done;
    r.err     = err;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/utfsg_parse.sv
// Input register and byte parser that builds the result run of each beat
`default_nettype none
`include "assert_macros.svh"

module utfsg_parse
  import utfsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            run_valid,
  input  wire logic       run_ready,
  output run_t            run
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;

  phase_t      phase, phase_next;
  logic [15:0] group_length, group_length_next;
  logic [16:0] bytes_consumed, bytes_consumed_next;
  logic [14:0] units_left, units_left_next;
  logic [7:0]  held_low_byte, held_low_byte_next;

  logic [16:0] bc_inc;
  logic        at_end;
  logic [15:0] cu;
  logic [14:0] ul_pfx2;
  logic [14:0] ul_dec;
  logic        do_settle;
  logic        str_done;
  phase_t      settle_ph;
  run_t        run_c;

  assign bc_inc  = bytes_consumed + 17'd1;
  assign at_end  = bc_inc >= {1'b0, group_length};
  assign cu      = {s1_byte, held_low_byte};
  assign ul_pfx2 = {held_low_byte[6:0], s1_byte};
  assign ul_dec  = (units_left != 15'd0) ? units_left - 15'd1 : units_left;

  always_comb begin
    phase_next          = phase;
    group_length_next   = group_length;
    bytes_consumed_next = bytes_consumed;
    units_left_next     = units_left;
    held_low_byte_next  = held_low_byte;
    do_settle           = 1'b0;
    str_done            = 1'b0;
    settle_ph           = phase;
    run_c               = '0;
    case (phase)
      PH_LEN_LO: begin
        held_low_byte_next = s1_byte;
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        group_length_next   = cu;
        bytes_consumed_next = '0;
        if (cu == 16'd0) begin
          run_c.res[0] = mk_res(8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
          run_c.count  = 3'd1;
          phase_next   = PH_LEN_LO;
        end else begin
          phase_next = PH_PFX1;
        end
      end
      PH_PFX1: begin
        bytes_consumed_next = bc_inc;
        do_settle           = 1'b1;
        if (s1_byte[7]) begin
          held_low_byte_next = {1'b0, s1_byte[6:0]};
          settle_ph          = PH_PFX2;
        end else begin
          units_left_next = {8'd0, s1_byte[6:0]};
          str_done        = (s1_byte[6:0] == 7'd0);
          settle_ph       = PH_UNIT_LO;
        end
      end
      PH_PFX2: begin
        bytes_consumed_next = bc_inc;
        units_left_next     = ul_pfx2;
        do_settle           = 1'b1;
        str_done            = (ul_pfx2 == 15'd0);
        settle_ph           = PH_UNIT_LO;
      end
      PH_UNIT_LO: begin
        bytes_consumed_next = bc_inc;
        held_low_byte_next  = s1_byte;
        do_settle           = 1'b1;
        settle_ph           = PH_UNIT_HI;
      end
      PH_UNIT_HI: begin
        bytes_consumed_next = bc_inc;
        if (cu[15:11] == 5'b11011) begin
          run_c.res[0] = mk_res(8'h00, 1'b0, 1'b0, 1'b1, ERR_SURROGATE);
          run_c.count  = 3'd1;
          phase_next   = at_end ? PH_LEN_LO : PH_DRAIN;
        end else begin
          if (cu[15:7] == 9'd0) begin
            run_c.res[0] = mk_res(cu[7:0], 1'b1, 1'b0, 1'b0, ERR_NONE);
            run_c.count  = 3'd1;
          end else if (cu[15:11] == 5'd0) begin
            run_c.res[0] = mk_res({3'b110, cu[10:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
            run_c.res[1] = mk_res({2'b10, cu[5:0]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
            run_c.count  = 3'd2;
          end else begin
            run_c.res[0] = mk_res({4'b1110, cu[15:12]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
            run_c.res[1] = mk_res({2'b10, cu[11:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
            run_c.res[2] = mk_res({2'b10, cu[5:0]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
            run_c.count  = 3'd3;
          end
          units_left_next = ul_dec;
          do_settle       = 1'b1;
          str_done        = (ul_dec == 15'd0);
          settle_ph       = PH_UNIT_LO;
        end
      end
      PH_DRAIN: begin
        bytes_consumed_next = bc_inc;
        if (at_end) begin
          phase_next = PH_LEN_LO;
        end
      end
      default: begin
        held_low_byte_next = s1_byte;
        phase_next         = PH_LEN_HI;
      end
    endcase

    if (do_settle) begin
      if (str_done) begin
        run_c.res[run_c.count[1:0]] = mk_res(8'h00, 1'b1, 1'b1, at_end, ERR_NONE);
        run_c.count = run_c.count + 3'd1;
        phase_next  = at_end ? PH_LEN_LO : PH_PFX1;
      end else if (at_end) begin
        run_c.res[run_c.count[1:0]] = mk_res(8'h00, 1'b0, 1'b0, 1'b1, ERR_OVERRUN);
        run_c.count = run_c.count + 3'd1;
        phase_next  = PH_LEN_LO;
      end else begin
        phase_next = settle_ph;
      end
    end
  end

  assign run       = run_c;
  assign run_valid = s1_valid && (run_c.count != 3'd0);
  assign advance   = s1_valid && ((run_c.count == 3'd0) || run_ready);
  assign in_stall  = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      phase          <= PH_LEN_LO;
      group_length   <= '0;
      bytes_consumed <= '0;
      units_left     <= '0;
      held_low_byte  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        phase          <= phase_next;
        group_length   <= group_length_next;
        bytes_consumed <= bytes_consumed_next;
        units_left     <= units_left_next;
        held_low_byte  <= held_low_byte_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
    end
  end

  `ASSERT_NEXT(a_hold_beat, clk, rst, s1_valid && !advance, s1_valid, "input beat lost while held")
  `ASSERT_ALWAYS(a_run_size, clk, rst, !s1_valid || (run_c.count <= 3'd4), "run larger than buffer")
  `ASSERT_ALWAYS(a_phase_onehot, clk, rst, $onehot(phase), "phase not one-hot")

endmodule

`default_nettype wire

// File: src/utfsg_emit.sv
// Run buffer and output register that send one result per cycle unless out_stall holds the output
`default_nettype none
`include "assert_macros.svh"

module utfsg_emit
  import utfsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       run_valid,
  output logic            run_ready,
  input  run_t            run,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            string_end,
  output logic            group_done,
  output logic [1:0]      error_code,
  output logic            last_of_run
);

  run_t       run_data;
  logic       run_busy;
  logic [1:0] idx;
  logic       out_free;
  logic       move;
  logic       is_last;
  logic       last_move;
  logic       load;
  result_t    cur;

  assign out_free  = !out_valid || !out_stall;
  assign move      = run_busy && out_free;
  assign is_last   = ({1'b0, idx} == (run_data.count - 3'd1));
  assign last_move = move && is_last;
  assign run_ready = !run_busy || last_move;
  assign load      = run_valid && run_ready;
  assign cur       = run_data.res[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      run_busy  <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        run_busy <= 1'b1;
        idx      <= '0;
      end else if (last_move) begin
        run_busy <= 1'b0;
      end else if (move) begin
        idx <= idx + 2'd1;
      end
      if (out_free) begin
        out_valid <= move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_data <= run;
    end
    if (move) begin
      out_byte    <= cur.valid ? cur.data : 8'h00;
      byte_valid  <= cur.valid;
      string_end  <= cur.str_end;
      group_done  <= cur.done;
      error_code  <= cur.err;
      last_of_run <= is_last;
    end
  end

  `ASSERT_ALWAYS(a_busy_count, clk, rst, !run_busy || (run_data.count != 3'd0), "empty run held")
  `ASSERT_ALWAYS(a_idx_range, clk, rst, !run_busy || ({1'b0, idx} < run_data.count), "index past run")
  `ASSERT_NEXT(a_load_start, clk, rst, load, run_busy && (idx == 2'd0), "run load not started at head")

endmodule

`default_nettype wire

// File: src/utf16_string_group_to_utf8_unit.sv
// Top level of the UTF-16 string group to UTF-8 converter
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  in_byte
//   out      out  out_valid/out_stall  out_byte byte_valid string_end group_done
//                                      error_code last_of_run
//
// A beat waits in the input register while the parser builds its run of zero
// to four results, which pass through the run buffer to the output register.
// The run buffer sends one result per cycle unless out_stall holds it; a beat
// with results waits until its run is taken. Beats with no result pass at one
// per cycle. Reset clears phase, counters, the held low byte and valid bits
// only. out_stall holds the output register and backs up to in_stall.
`default_nettype none

module utf16_string_group_to_utf8_unit
  import utfsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            string_end,
  output logic            group_done,
  output logic [1:0]      error_code,
  output logic            last_of_run
);

  run_t run;
  logic run_valid;
  logic run_ready;

  utfsg_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run       (run)
  );

  utfsg_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .run_valid   (run_valid),
    .run_ready   (run_ready),
    .run         (run),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .string_end  (string_end),
    .group_done  (group_done),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
